### hw/rtl/arof_pkg.sv
// Shared types, constants and helpers of the alignment region overlap filter.
package arof_pkg;

  localparam int COUNT_BITS     = 40;
  localparam int TOTAL_BITS     = 40;
  localparam int SPAN_BITS      = 31;
  localparam int ID_BITS        = 31;
  localparam int POS_BITS       = 32;
  localparam int WORD_BITS      = 32;
  localparam int OPCODE_BITS    = 4;
  localparam int LEN_BITS       = WORD_BITS - OPCODE_BITS;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [SPAN_BITS-1:0] SPAN_MAX = '1;

  // CIGAR opcodes that consume reference bases.
  localparam logic [OPCODE_BITS-1:0] OP_MATCH    = 4'd0;
  localparam logic [OPCODE_BITS-1:0] OP_DELETE   = 4'd2;
  localparam logic [OPCODE_BITS-1:0] OP_SKIP     = 4'd3;
  localparam logic [OPCODE_BITS-1:0] OP_SEQ_EQ   = 4'd7;
  localparam logic [OPCODE_BITS-1:0] OP_SEQ_DIFF = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_REFERENCE = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_FIRST     = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_LAST      = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SORTED_MODE      = 4'd3;

  localparam logic signed [POS_BITS-1:0] REGION_LAST_RESET = 32'sd2147483646;

  typedef struct packed {
    logic [ID_BITS-1:0]         target_reference;
    logic [ID_BITS-1:0]         region_first;
    logic signed [POS_BITS-1:0] region_last;
    logic                       sorted_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] record_reference;
    logic signed [POS_BITS-1:0] record_start;
    logic [WORD_BITS-1:0]       cigar_word;
    logic                       word_present;
    logic                       record_end_mark;
  } item_t;

  typedef struct packed {
    logic [SPAN_BITS-1:0]  span_sum;
    logic                  stop_flag;
    logic [COUNT_BITS-1:0] count;
  } state_t;

  function automatic logic consumes_reference(input logic [OPCODE_BITS-1:0] op);
    return (op == OP_MATCH) || (op == OP_DELETE) || (op == OP_SKIP) ||
           (op == OP_SEQ_EQ) || (op == OP_SEQ_DIFF);
  endfunction

endpackage

### hw/rtl/arof_in_if.sv
// Input channel: one CIGAR operation of an alignment record per transaction.
interface arof_in_if;
  import arof_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] record_reference;
  logic signed [POS_BITS-1:0] record_start;
  logic [WORD_BITS-1:0]       cigar_word;
  logic                       word_present;
  logic                       record_end_mark;

  modport source (output valid, output record_reference, output record_start,
                  output cigar_word, output word_present, output record_end_mark,
                  input ready);
  modport sink (input valid, input record_reference, input record_start,
                input cigar_word, input word_present, input record_end_mark,
                output ready);
endinterface

### hw/rtl/arof_out_if.sv
// Result channel: one filter verdict per completed record.
interface arof_out_if;
  import arof_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  selected;
  logic                  scan_stopped;
  logic [SPAN_BITS-1:0]  reference_span;
  logic [TOTAL_BITS-1:0] match_total;

  modport source (output valid, output selected, output scan_stopped,
                  output reference_span, output match_total, input ready);
  modport sink (input valid, input selected, input scan_stopped,
                input reference_span, input match_total, output ready);
endinterface

### hw/rtl/alignment_region_overlap_filter.sv
// Top level of the alignment region overlap filter.
//
//  channel   direction  handshake      transaction
//  in_ch     in         valid/ready    one CIGAR operation with record id and start
//  out_ch    out        valid/ready    one verdict per record, on its last operation
//  cfg_*     in         write enable   one register write, no read-back
//
// An item is registered on acceptance and evaluated from the input register, so a new
// item can be taken every cycle unless a record's last item is held there; out_ch.valid
// is set in the result register when a record's last item leaves the input register.
// Throughput is one item per cycle outside such stalls, set by the single input register stage.
// Reset is synchronous, clears the span sum, stop flag, counter and valid flags, and loads config defaults.
// While a result waits on out_ch, non-final items keep flowing; only a record's
// last item waits in the input register until the result register frees up.
module alignment_region_overlap_filter
  import arof_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  arof_in_if.sink                   in_ch,
  arof_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  cfg_t   cfg_r;
  state_t state_r;
  state_t state_nxt;
  item_t  s1_item_r;
  logic   s1_valid_r;
  logic   s1_adv;
  logic   in_accept;
  logic   eval_selected;
  logic [SPAN_BITS-1:0] eval_span;
  logic [63:0]          count_ext;

  logic                  out_valid_r;
  logic                  out_selected_r;
  logic                  out_stopped_r;
  logic [SPAN_BITS-1:0]  out_span_r;
  logic [TOTAL_BITS-1:0] out_total_r;

  arof_eval u_eval (
    .cfg       (cfg_r),
    .item      (s1_item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .selected  (eval_selected),
    .span      (eval_span)
  );

  assign s1_adv = s1_valid_r &&
                  (!s1_item_r.record_end_mark || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign count_ext   = 64'(state_nxt.count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r             <= 1'b0;
      out_valid_r            <= 1'b0;
      state_r                <= '0;
      cfg_r.target_reference <= '0;
      cfg_r.region_first     <= '0;
      cfg_r.region_last      <= REGION_LAST_RESET;
      cfg_r.sorted_mode      <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (s1_adv && s1_item_r.record_end_mark) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET_REFERENCE: cfg_r.target_reference <= cfg_wdata[ID_BITS-1:0];
          REG_REGION_FIRST:     cfg_r.region_first     <= cfg_wdata[ID_BITS-1:0];
          REG_REGION_LAST:      cfg_r.region_last      <= $signed(cfg_wdata[POS_BITS-1:0]);
          REG_SORTED_MODE:      cfg_r.sorted_mode      <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.record_reference <= in_ch.record_reference;
      s1_item_r.record_start     <= in_ch.record_start;
      s1_item_r.cigar_word       <= in_ch.cigar_word;
      s1_item_r.word_present     <= in_ch.word_present;
      s1_item_r.record_end_mark  <= in_ch.record_end_mark;
    end
    if (s1_adv && s1_item_r.record_end_mark) begin
      out_selected_r <= eval_selected;
      out_stopped_r  <= state_nxt.stop_flag;
      out_span_r     <= eval_span;
      out_total_r    <= count_ext[TOTAL_BITS-1:0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.selected       = out_selected_r;
  assign out_ch.scan_stopped   = out_stopped_r;
  assign out_ch.reference_span = out_span_r;
  assign out_ch.match_total    = out_total_r;

endmodule

### hw/rtl/arof_eval.sv
// Span accumulation and region overlap decision for one registered item.
module arof_eval
  import arof_pkg::*;
(
  input  cfg_t                 cfg,
  input  item_t                item,
  input  state_t               state,
  output state_t               state_nxt,
  output logic                 selected,
  output logic [SPAN_BITS-1:0] span
);

  logic [LEN_BITS-1:0]    op_len;
  logic [OPCODE_BITS-1:0] op_code;
  logic [SPAN_BITS:0]     sum_wide;
  logic [SPAN_BITS-1:0]   sum_acc;
  logic signed [POS_BITS:0]   tgt_s;
  logic signed [POS_BITS:0]   ref_s;
  logic signed [POS_BITS+1:0] end_s;
  logic signed [POS_BITS+1:0] first_s;
  logic ref_eq;
  logic ref_gt;
  logic past_last;
  logic starts_before;
  logic ends_before;
  logic stop_set;
  logic sel;

  assign op_len  = item.cigar_word[WORD_BITS-1:OPCODE_BITS];
  assign op_code = item.cigar_word[OPCODE_BITS-1:0];
  assign sum_wide = {1'b0, state.span_sum} + (SPAN_BITS+1)'(op_len);

  always_comb begin
    if (item.word_present && consumes_reference(op_code)) begin
      sum_acc = sum_wide[SPAN_BITS] ? SPAN_MAX : sum_wide[SPAN_BITS-1:0];
    end else begin
      sum_acc = state.span_sum;
    end
  end

  assign span = (sum_acc == '0) ? SPAN_BITS'(1) : sum_acc;

  assign tgt_s   = $signed({2'b00, cfg.target_reference});
  assign ref_s   = $signed({item.record_reference[POS_BITS-1], item.record_reference});
  assign ref_eq  = (ref_s == tgt_s);
  assign ref_gt  = (ref_s > tgt_s);
  assign past_last = (item.record_start > cfg.region_last);

  // End position is start + span - 1, kept wide enough that it never wraps.
  assign end_s   = $signed({{2{item.record_start[POS_BITS-1]}}, item.record_start})
                 + $signed({3'b000, span}) - 34'sd1;
  assign first_s = $signed({3'b000, cfg.region_first});
  assign starts_before = ($signed({{2{item.record_start[POS_BITS-1]}}, item.record_start})
                          < first_s);
  assign ends_before   = (end_s < first_s);

  always_comb begin
    stop_set = 1'b0;
    sel      = 1'b0;
    if (item.record_end_mark && !state.stop_flag) begin
      priority if (!ref_eq) begin
        stop_set = cfg.sorted_mode && ref_gt;
      end else if (past_last) begin
        stop_set = cfg.sorted_mode;
      end else begin
        sel = !(starts_before && ends_before);
      end
    end
  end

  assign selected            = sel;
  assign state_nxt.span_sum  = item.record_end_mark ? '0 : sum_acc;
  assign state_nxt.stop_flag = state.stop_flag | stop_set;
  assign state_nxt.count     = state.count + COUNT_BITS'(sel);

endmodule

### hw/rtl/arof_checker.sv
// Port-level assertions for the alignment region overlap filter, with its bind.
module arof_checker
  import arof_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_selected,
  input logic                  out_scan_stopped,
  input logic [SPAN_BITS-1:0]  out_reference_span,
  input logic [TOTAL_BITS-1:0] out_match_total
);

  logic                  out_accept;
  logic                  stopped_seen_r;
  logic [TOTAL_BITS-1:0] last_total_r;

  assign out_accept = out_valid && out_ready;

  // Track what earlier result transactions reported.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_seen_r <= 1'b0;
      last_total_r   <= '0;
    end else if (out_accept) begin
      stopped_seen_r <= stopped_seen_r | out_scan_stopped;
      last_total_r   <= out_match_total;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_selected) &&
    $stable(out_scan_stopped) && $stable(out_reference_span) && $stable(out_match_total))
    else $error("result changed while stalled");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_accept && stopped_seen_r |-> out_scan_stopped && !out_selected)
    else $error("record selected or stop cleared after scan stopped");

  a_total_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_accept |-> out_match_total == last_total_r + TOTAL_BITS'(out_selected))
    else $error("match total does not follow selected records");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

endmodule

bind alignment_region_overlap_filter arof_checker u_arof_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_selected       (out_ch.selected),
  .out_scan_stopped   (out_ch.scan_stopped),
  .out_reference_span (out_ch.reference_span),
  .out_match_total    (out_ch.match_total)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the alignment region overlap filter.
module testbench;
  import arof_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER_ITEMS = 1500;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 4'd15;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic                  selected;
    logic                  scan_stopped;
    logic [SPAN_BITS-1:0]  reference_span;
    logic [TOTAL_BITS-1:0] match_total;
  } verdict_t;

  class region_scoreboard;
    logic [ID_BITS-1:0]         target_ref;
    logic [ID_BITS-1:0]         first_pos;
    logic signed [POS_BITS-1:0] last_pos;
    logic                       sorted;
    logic [SPAN_BITS-1:0]       span_acc;
    logic                       stopped;
    logic [COUNT_BITS-1:0]      select_count;
    verdict_t                   expected_verdicts[$];
    int                         mismatches;

    function new();
      target_ref = '0;
      first_pos = '0;
      last_pos = REGION_LAST_RESET;
      sorted = 1'b0;
      span_acc = '0;
      stopped = 1'b0;
      select_count = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_TARGET_REFERENCE: target_ref = data[ID_BITS-1:0];
        REG_REGION_FIRST: first_pos = data[ID_BITS-1:0];
        REG_REGION_LAST: last_pos = data;
        REG_SORTED_MODE: sorted = data[0];
        default: ;
      endcase
    endfunction

    function bit adds_to_span(logic [OPCODE_BITS-1:0] op);
      return op inside {OP_MATCH, OP_DELETE, OP_SKIP, OP_SEQ_EQ, OP_SEQ_DIFF};
    endfunction

    function void note_item(item_t it);
      logic [SPAN_BITS:0]   span_total;
      logic [SPAN_BITS-1:0] span;
      longint               rec_id;
      longint               rec_pos;
      longint               tgt;
      longint               first;
      longint               last_l;
      longint               span_l;
      verdict_t             v;
      if (it.word_present && adds_to_span(it.cigar_word[OPCODE_BITS-1:0])) begin
        span_total = {1'b0, span_acc} +
                     (SPAN_BITS+1)'(it.cigar_word[WORD_BITS-1:OPCODE_BITS]);
        span_acc = (span_total > {1'b0, SPAN_MAX}) ? SPAN_MAX : span_total[SPAN_BITS-1:0];
      end
      if (!it.record_end_mark) return;
      span = (span_acc == '0) ? SPAN_BITS'(1) : span_acc;
      span_acc = '0;
      v.selected = 1'b0;
      if (!stopped) begin
        rec_id = longint'($signed(it.record_reference));
        rec_pos = longint'($signed(it.record_start));
        tgt = longint'({1'b0, target_ref});
        first = longint'({1'b0, first_pos});
        last_l = longint'($signed(last_pos));
        span_l = longint'({1'b0, span});
        // A record past the region in either coordinate ends a sorted scan.
        if (rec_id != tgt) begin
          if (sorted && rec_id > tgt) stopped = 1'b1;
        end else if (rec_pos > last_l) begin
          if (sorted) stopped = 1'b1;
        end else if (!(rec_pos < first && rec_pos + span_l - 1 < first)) begin
          v.selected = 1'b1;
          select_count = select_count + 1'b1;
        end
      end
      v.scan_stopped = stopped;
      v.reference_span = span;
      v.match_total = select_count;
      expected_verdicts.push_back(v);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result transaction with no record pending");
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.selected !== want.selected)
        report_mismatch($sformatf("selected %0b, expected %0b", got.selected, want.selected));
      if (got.scan_stopped !== want.scan_stopped)
        report_mismatch($sformatf("scan_stopped %0b, expected %0b",
                                  got.scan_stopped, want.scan_stopped));
      if (got.reference_span !== want.reference_span)
        report_mismatch($sformatf("reference_span %0d, expected %0d",
                                  got.reference_span, want.reference_span));
      if (got.match_total !== want.match_total)
        report_mismatch($sformatf("match_total %0d, expected %0d",
                                  got.match_total, want.match_total));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic hold_off;
  int items_accepted;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;
  region_scoreboard sb;

  arof_in_if in_ch();
  arof_out_if out_ch();

  alignment_region_overlap_filter DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: check each transaction, then pick the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_verdict({out_ch.selected, out_ch.scan_stopped, out_ch.reference_span,
                        out_ch.match_total});
    out_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // One long back-pressure stretch so that the input side fills up and stalls.
  initial begin
    hold_off = 1'b0;
    wait (items_accepted >= HOLD_AFTER_ITEMS);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.record_reference <= it.record_reference;
    in_ch.record_start <= it.record_start;
    in_ch.cigar_word <= it.cigar_word;
    in_ch.word_present <= it.word_present;
    in_ch.record_end_mark <= it.record_end_mark;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
    items_accepted++;
    if (items_accepted == 650) begin
      send_idle_pct = 80;
      recv_idle_pct = 23;
    end else if (items_accepted == 1300) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Unused upper bits are randomized; a write to an unmapped index must be ignored.
  task automatic configure(logic [ID_BITS-1:0] tgt, logic [ID_BITS-1:0] first,
                           logic signed [POS_BITS-1:0] last, logic sorted);
    write_reg(REG_TARGET_REFERENCE, {1'($urandom), tgt});
    write_reg(REG_REGION_FIRST, {1'($urandom), first});
    write_reg(REG_REGION_LAST, last);
    write_reg(REG_SORTED_MODE, {31'($urandom), sorted});
    write_reg(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [WORD_BITS-1:0] random_op();
    logic [OPCODE_BITS-1:0] op;
    logic [LEN_BITS-1:0] len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      case ($urandom_range(4))
        0: op = OP_MATCH;
        1: op = OP_DELETE;
        2: op = OP_SKIP;
        3: op = OP_SEQ_EQ;
        default: op = OP_SEQ_DIFF;
      endcase
    end else begin
      op = $urandom_range(15);
    end
    pick = $urandom_range(99);
    if (pick < 80) len = $urandom_range(400);
    else if (pick < 95) len = $urandom;
    else len = LEN_MAX;
    return {len, op};
  endfunction

  function automatic logic signed [POS_BITS-1:0] pick_id(longint tgt);
    case ($urandom_range(9))
      6: return (tgt == 64'h7FFF_FFFF) ? 32'(tgt) : 32'(tgt + 1);
      7: return 32'(tgt - 1);
      8: return -32'sd1;
      9: return $urandom & 32'h7FFF_FFFF;
      default: return 32'(tgt);
    endcase
  endfunction

  function automatic logic signed [POS_BITS-1:0] pick_start(longint first, longint last);
    longint lo;
    longint hi;
    longint p;
    lo = first - 600;
    hi = ((last > first) ? last : first) + 600;
    case ($urandom_range(9))
      4: p = first - $urandom_range(600);
      5: p = last - 300 + $urandom_range(600);
      6: p = -1;
      7: p = 64'h7FFF_FFFF - $urandom_range(3);
      8, 9: p = $urandom & 32'h7FFF_FFFF;
      default: p = lo + $urandom_range(32'(hi - lo));
    endcase
    if (p < -1) p = -1;
    if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
    return 32'(p);
  endfunction

  function automatic int pick_ops();
    return ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
  endfunction

  // Only the last item carries the real id and start; earlier ones get noise there.
  task automatic send_record(logic signed [POS_BITS-1:0] rec_id,
                             logic signed [POS_BITS-1:0] rec_pos, int n_ops);
    item_t it;
    if (n_ops == 0) begin
      it.record_reference = rec_id;
      it.record_start = rec_pos;
      it.cigar_word = $urandom;
      it.word_present = 1'b0;
      it.record_end_mark = 1'b1;
      send_item(it);
    end
    for (int i = 0; i < n_ops; i++) begin
      it.record_reference = (i == n_ops - 1) ? rec_id : $urandom;
      it.record_start = (i == n_ops - 1) ? rec_pos : $urandom;
      it.cigar_word = random_op();
      it.word_present = ($urandom_range(9) != 0);
      it.record_end_mark = (i == n_ops - 1);
      send_item(it);
    end
  endtask

  task automatic send_single(logic signed [POS_BITS-1:0] rec_id,
                             logic signed [POS_BITS-1:0] rec_pos,
                             logic [WORD_BITS-1:0] word, logic present);
    item_t it;
    it.record_reference = rec_id;
    it.record_start = rec_pos;
    it.cigar_word = word;
    it.word_present = present;
    it.record_end_mark = 1'b1;
    send_item(it);
  endtask

  // Region is [100, 200] on reference 5.
  task automatic run_directed();
    item_t it;
    logic [OPCODE_BITS-1:0] op;
    // Every opcode at full length; nine of them consume reference, so the sum saturates.
    for (int i = 0; i < 20; i++) begin
      case (i)
        16: op = OP_MATCH;
        17: op = OP_DELETE;
        18: op = OP_SKIP;
        19: op = OP_SEQ_EQ;
        default: op = i[OPCODE_BITS-1:0];
      endcase
      it.record_reference = (i == 19) ? 32'sd5 : $urandom;
      it.record_start = (i == 19) ? 32'sd99 : $urandom;
      it.cigar_word = {LEN_MAX, op};
      it.word_present = 1'b1;
      it.record_end_mark = (i == 19);
      send_item(it);
    end
    send_single(32'sd5, 32'sd150, {LEN_MAX, OP_MATCH}, 1'b0);
    send_single(-32'sd1, 32'sd150, {28'd10, OP_MATCH}, 1'b1);
    send_single(32'sd5, -32'sd1, {28'd101, OP_MATCH}, 1'b1);
    send_single(32'sd5, -32'sd1, {28'd102, OP_DELETE}, 1'b1);
    send_single(32'sd5, 32'sd200, {28'd0, OP_MATCH}, 1'b1);
    send_single(32'sd5, 32'sd201, {28'd50, OP_SKIP}, 1'b1);
    send_single(32'sd5, 32'sh7FFF_FFFF, {LEN_MAX, OP_SEQ_DIFF}, 1'b1);
  endtask

  task automatic run_random(int budget);
    int start;
    start = items_accepted;
    while (items_accepted - start < budget)
      send_record(pick_id(sb.target_ref), pick_start(sb.first_pos, $signed(sb.last_pos)),
                  pick_ops());
  endtask

  // Coordinate-ordered records that walk up to and past the region, then noise.
  task automatic run_sorted(int budget);
    int start;
    longint tgt;
    longint pos;
    longint pos_end;
    bit by_ref;
    start = items_accepted;
    tgt = sb.target_ref;
    by_ref = $urandom_range(1);
    pos_end = by_ref ? longint'($signed(sb.last_pos)) - 1000 : $signed(sb.last_pos) + 1000;
    repeat (3) send_record(32'(tgt - 1), $urandom & 32'h7FFF_FFFF, pick_ops());
    pos = 0;
    while (pos <= pos_end) begin
      send_record(32'(tgt), 32'(pos), pick_ops());
      pos += $urandom_range(300);
    end
    if (by_ref) repeat (3) send_record(32'(tgt + 1), $urandom_range(5000), pick_ops());
    run_random(budget - (items_accepted - start));
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.record_reference = '0;
    in_ch.record_start = '0;
    in_ch.cigar_word = '0;
    in_ch.word_present = 1'b0;
    in_ch.record_end_mark = 1'b0;
    out_ch.ready = 1'b0;
    items_accepted = 0;
    cycles = 0;
    send_idle_pct = 23;
    recv_idle_pct = 80;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(31'd5, 31'd100, 32'sd200, 1'b0);
    run_directed();
    drain();

    configure($urandom_range(1000, 1), $urandom_range(100000), 32'sd0, 1'b0);
    configure(sb.target_ref, sb.first_pos, sb.first_pos + $urandom_range(50000), 1'b0);
    run_random(700);
    drain();

    configure(31'h7FFF_FFFF, 31'd2147483646, 32'sd2147483646, 1'b0);
    run_random(350);
    drain();

    // Empty region: last lies below first.
    configure(31'd0, 31'd0, -32'sd1, 1'b0);
    run_random(250);
    drain();

    configure(31'd2, 31'd2000, 32'sd8000, 1'b1);
    run_sorted(650);
    drain();

    if (sb.mismatches == 0 && sb.expected_verdicts.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### files.f
hw/rtl/arof_pkg.sv
hw/rtl/arof_in_if.sv
hw/rtl/arof_out_if.sv
hw/rtl/arof_eval.sv
hw/rtl/alignment_region_overlap_filter.sv
hw/rtl/arof_checker.sv
sim/testbench.sv
